### sv/array_sort_or_reverse_unit_defines.svh
// Assertion macros shared by the sort/reverse unit.
`ifndef ARRAY_SORT_OR_REVERSE_UNIT_DEFINES_SVH
`define ARRAY_SORT_OR_REVERSE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ASRU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define ASRU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/asru_pkg.sv
// Package for the sort/reverse unit: word types and method codes.
package asru_pkg;

   localparam int DATA_WIDTH = 32;

   localparam logic [1:0] METHOD_BUBBLE    = 2'd0;
   localparam logic [1:0] METHOD_SELECTION = 2'd1;
   localparam logic [1:0] METHOD_INSERTION = 2'd2;
   localparam logic [1:0] METHOD_REVERSE   = 2'd3;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         is_last;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_value;
      logic                         result_last;
   } rsp_word_type;

endpackage

### sv/asru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/array_sort_or_reverse_unit.sv
// Top level of the sort/reverse unit: loader, bubble engine and output sequencer.
//
// Usage:
//  - Input words (req_word) are taken at a clock edge with req_start high and busy low.
//    Words are stored in order; words beyond DEPTH are dropped. A word with is_last set
//    ends the set (it is stored like the others, if there is room).
//  - csr_we/csr_wdata write the method register (0 bubble, 1 selection, 2 insertion,
//    3 reverse). Write it only while busy is low; it is sampled at the is_last word.
//  - Methods 0..2 all produce the same ascending signed order; this design runs all of
//    them on one bubble engine: a single signed compare plus a carry register that holds
//    the element being bubbled, so each pass does one RAM read and one RAM write a cycle.
//  - Results leave on rsp_word, one per cycle, each marked by rsp_strobe for exactly one
//    cycle; result_last flags the final one. The receiver cannot stall the block.
// Sequence, with n the set size:
//  - Non-final words are stored while busy stays low.
//  - Sort: passes of m = n down to 2 elements, each reading entries 0 and 1, then
//    scanning, then writing the carry; bounded by the single RAM read/write port pair.
//  - Output: S_OUT_ADDR issues the first read, then n strobes follow on consecutive cycles;
//    busy drops after the last strobe. Reverse order (or n = 1) skips the sort entirely.
// Reset (synchronous, active high) empties the set, clears the method to bubble and
// returns to idle. Store contents are not cleared; every entry is written before use.
module array_sort_or_reverse_unit #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   input  asru_pkg::req_word_type req_word,
   output logic                  busy,
   output logic                  rsp_strobe,
   output asru_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic [1:0]            csr_wdata
);

   import asru_pkg::*;

   `include "array_sort_or_reverse_unit_defines.svh"

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // store index
   localparam int CW = $clog2(DEPTH + 1);                // element count

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_FIRST    = 3'd1;  // issue read of entry 0
   localparam logic [2:0] S_SECOND   = 3'd2;  // load carry, issue read of entry 1
   localparam logic [2:0] S_SCAN     = 3'd3;  // compare/write, advance
   localparam logic [2:0] S_TAIL     = 3'd4;  // write carry at end of pass
   localparam logic [2:0] S_OUT_ADDR = 3'd5;  // issue first output read
   localparam logic [2:0] S_OUT      = 3'd6;  // present one word per cycle

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;   // set size; n while busy
   logic [CW-1:0]         m_ff, m_in;           // current pass length
   logic [IW-1:0]         j_ff, j_in;           // carry position in pass
   logic [IW-1:0]         k_ff, k_in;           // output position
   logic [DATA_WIDTH-1:0] carry_ff, carry_in;
   logic                  rev_ff, rev_in;
   logic [1:0]            method_ff, method_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [IW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   logic [CW-1:0]         load_count;
   logic [CW-1:0]         out_pos;
   logic [CW-1:0]         out_rev;
   logic                  out_last;

   asru_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next output position to read: 0 in S_OUT_ADDR, k+1 in S_OUT
   assign out_pos  = (state_ff == S_OUT) ? (CW'(k_ff) + CW'(1)) : '0;
   assign out_rev  = count_ff - CW'(1) - out_pos;
   assign out_last = ((CW'(k_ff) + CW'(1)) == count_ff);

   assign load_count = (count_ff < CW'(DEPTH)) ? (count_ff + CW'(1)) : count_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      m_in      = m_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      carry_in  = carry_ff;
      rev_in    = rev_ff;
      method_in = csr_we ? csr_wdata : method_ff;
      wr_en     = 1'b0;
      wr_addr   = j_ff;
      wr_data   = carry_ff;
      rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               if (count_ff < CW'(DEPTH)) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[IW-1:0];
                  wr_data = req_word.value;
               end
               count_in = load_count;
               if (req_word.is_last) begin
                  rev_in = (method_ff == METHOD_REVERSE);
                  m_in   = load_count;
                  if (method_ff == METHOD_REVERSE || load_count < CW'(2)) begin
                     state_in = S_OUT_ADDR;
                  end else begin
                     state_in = S_FIRST;
                  end
               end
            end
         end
         S_FIRST: begin
            rd_addr  = '0;
            state_in = S_SECOND;
         end
         S_SECOND: begin
            carry_in = rd_data;
            rd_addr  = IW'(1);
            j_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // smaller value stays at j, larger keeps bubbling
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if ($signed(carry_ff) > $signed(rd_data)) begin
               wr_data = rd_data;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data;
            end
            rd_addr = j_ff + IW'(2);
            j_in    = j_ff + IW'(1);
            if ((CW'(j_ff) + CW'(2)) == m_ff) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = carry_ff;
            m_in    = m_ff - CW'(1);
            if (m_ff <= CW'(2)) begin
               state_in = S_OUT_ADDR;
            end else begin
               state_in = S_FIRST;
            end
         end
         S_OUT_ADDR: begin
            rd_addr  = rev_ff ? out_rev[IW-1:0] : out_pos[IW-1:0];
            k_in     = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            rd_addr = rev_ff ? out_rev[IW-1:0] : out_pos[IW-1:0];
            k_in    = k_ff + IW'(1);
            if (out_last) begin
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         method_ff <= METHOD_BUBBLE;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         method_ff <= method_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      carry_ff <= carry_in;
      rev_ff   <= rev_in;
   end

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_strobe            = (state_ff == S_OUT);
   assign rsp_word.result_value = rd_data;
   assign rsp_word.result_last  = out_last;

   // checks
   `ASRU_ASSERT_NOW(a_strobe_busy, rsp_strobe, busy, "result strobe while idle")
   `ASRU_ASSERT_NEXT(a_last_starts, req_start && !busy && req_word.is_last, busy, "set end did not start run")
   `ASRU_ASSERT_NEXT(a_last_ends, rsp_strobe && rsp_word.result_last, !busy && count_ff == '0, "run did not end after last word")
   `ASRU_ASSERT_NOW(a_count_range, busy, count_ff != '0 && count_ff <= CW'(DEPTH), "set size out of range while busy")

endmodule
